/* hdl/ffpa_pkg.sv */
// ffpa_pkg: shared types and constants of the first-fit pool allocator
// no dependencies
`timescale 1ns / 1ps

package ffpa_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int OFF_W      = 36;
    localparam int ALN_W      = 35;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_NOT_FND  = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        REG_POOL  = 2'd0,
        REG_ALIGN = 2'd1,
        REG_BASE  = 2'd2,
        REG_NONE  = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_SCAN_RD,
        FS_SCAN_CMP,
        FS_SH_RD,
        FS_SH_WR,
        FS_DONE
    } fsm_t;

endpackage

/* hdl/first_fit_pool_allocator_top.sv */
// first_fit_pool_allocator_top: block table in one memory, walked by a sequencer
// depends on ffpa_pkg
// one request at a time; the next request is taken in the cycle after the response is
// loaded; the single-port table read sets the pace
// reset clears the live count, bytes in use and registers (alignment 2^8); table needs no clear
`timescale 1ns / 1ps

module first_fit_pool_allocator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic        opcode,
    input  logic [31:0] request_bytes,
    input  logic [47:0] free_address,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [1:0]  status,
    output logic [47:0] granted_address,
    output logic [31:0] released_bytes,
    output logic [31:0] bytes_in_use,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int IW = ffpa_pkg::IDX_W;
    localparam int CW = ffpa_pkg::CNT_W;
    localparam int OW = ffpa_pkg::OFF_W;
    localparam int AW = ffpa_pkg::ALN_W;

    // configuration
    logic [31:0] pool_reg;
    logic [4:0]  align_reg;
    logic [47:0] base_reg;
    ffpa_pkg::reg_idx_t ridx;

    assign pready = 1'b1;
    assign ridx   = ffpa_pkg::reg_idx_t'(paddr[4:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_reg  <= '0;
            align_reg <= 5'd8;
            base_reg  <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (ridx)
                ffpa_pkg::REG_POOL:  pool_reg  <= pwdata[31:0];
                ffpa_pkg::REG_ALIGN: align_reg <= pwdata[4:0];
                ffpa_pkg::REG_BASE:  base_reg  <= pwdata[47:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (ridx)
            ffpa_pkg::REG_POOL:  prdata = {32'd0, pool_reg};
            ffpa_pkg::REG_ALIGN: prdata = {59'd0, align_reg};
            ffpa_pkg::REG_BASE:  prdata = {16'd0, base_reg};
            default:             prdata = '0;
        endcase
    end

    // block table: {start, length}
    logic [63:0]   mem [ffpa_pkg::MAX_BLOCKS];
    logic [63:0]   mem_q_reg;
    logic          mem_we;
    logic [IW-1:0] mem_wa;
    logic [IW-1:0] mem_ra;
    logic [63:0]   mem_wd;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        mem_q_reg <= mem[mem_ra];
    end

    // sequencer state
    ffpa_pkg::fsm_t    state_reg, state_next;
    ffpa_pkg::opcode_t op_reg, op_next;
    ffpa_pkg::status_t st_reg, st_next;
    logic [31:0] size_reg, size_next;
    logic [47:0] foff_reg, foff_next;
    logic [OW-1:0] off_reg, off_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] live_reg, live_next;
    logic [31:0] used_reg, used_next;
    logic [47:0] grant_reg, grant_next;
    logic [31:0] rel_reg, rel_next;

    logic        rsp_valid_reg, rsp_valid_next;
    ffpa_pkg::status_t rsp_st_reg, rsp_st_next;
    logic [47:0] rsp_grant_reg, rsp_grant_next;
    logic [31:0] rsp_rel_reg, rsp_rel_next;
    logic [31:0] rsp_used_reg, rsp_used_next;

    logic [31:0]   e_start;
    logic [31:0]   e_len;
    logic [AW-1:0] e_end;
    logic [AW-1:0] a_mask;
    logic [AW-1:0] e_aligned;
    logic [OW-1:0] cand_end;

    assign e_start   = mem_q_reg[63:32];
    assign e_len     = mem_q_reg[31:0];
    assign e_end     = AW'(e_start) + AW'(e_len);
    assign a_mask    = {AW{1'b1}} << align_reg;
    assign e_aligned = (e_end + ~a_mask) & a_mask;
    assign cand_end  = off_reg + OW'(size_reg);

    assign req_stall       = (state_reg != ffpa_pkg::FS_IDLE);
    assign rsp_valid       = rsp_valid_reg;
    assign status          = rsp_st_reg;
    assign granted_address = rsp_grant_reg;
    assign released_bytes  = rsp_rel_reg;
    assign bytes_in_use    = rsp_used_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ffpa_pkg::FS_IDLE;
            live_reg      <= '0;
            used_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            live_reg      <= live_next;
            used_reg      <= used_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        st_reg        <= st_next;
        size_reg      <= size_next;
        foff_reg      <= foff_next;
        off_reg       <= off_next;
        idx_reg       <= idx_next;
        pos_reg       <= pos_next;
        grant_reg     <= grant_next;
        rel_reg       <= rel_next;
        rsp_st_reg    <= rsp_st_next;
        rsp_grant_reg <= rsp_grant_next;
        rsp_rel_reg   <= rsp_rel_next;
        rsp_used_reg  <= rsp_used_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        st_next        = st_reg;
        size_next      = size_reg;
        foff_next      = foff_reg;
        off_next       = off_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        live_next      = live_reg;
        used_next      = used_reg;
        grant_next     = grant_reg;
        rel_next       = rel_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_st_next    = rsp_st_reg;
        rsp_grant_next = rsp_grant_reg;
        rsp_rel_next   = rsp_rel_reg;
        rsp_used_next  = rsp_used_reg;
        mem_we         = 1'b0;
        mem_wa         = idx_reg[IW-1:0];
        mem_wd         = mem_q_reg;
        mem_ra         = idx_reg[IW-1:0];

        unique case (state_reg)
            ffpa_pkg::FS_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = ffpa_pkg::opcode_t'(opcode);
                    size_next  = request_bytes;
                    foff_next  = free_address - base_reg;
                    off_next   = '0;
                    idx_next   = '0;
                    grant_next = '0;
                    rel_next   = '0;
                    st_next    = ffpa_pkg::ST_OK;
                    state_next = ffpa_pkg::FS_SCAN_RD;
                    if (opcode == ffpa_pkg::OP_ALLOC)
                    begin
                        if (request_bytes == 32'd0)
                        begin
                            st_next    = ffpa_pkg::ST_NO_SPACE;
                            state_next = ffpa_pkg::FS_DONE;
                        end
                        else if (live_reg >= CW'(ffpa_pkg::MAX_BLOCKS))
                        begin
                            st_next    = ffpa_pkg::ST_FULL;
                            state_next = ffpa_pkg::FS_DONE;
                        end
                    end
                end
            end
            ffpa_pkg::FS_SCAN_RD:
            begin
                if (idx_reg == live_reg)
                begin
                    if (op_reg == ffpa_pkg::OP_FREE)
                    begin
                        st_next    = ffpa_pkg::ST_NOT_FND;
                        state_next = ffpa_pkg::FS_DONE;
                    end
                    else if (cand_end > OW'(pool_reg))
                    begin
                        st_next    = ffpa_pkg::ST_NO_SPACE;
                        state_next = ffpa_pkg::FS_DONE;
                    end
                    else
                    begin
                        pos_next   = idx_reg;
                        state_next = ffpa_pkg::FS_SH_RD;
                    end
                end
                else
                begin
                    state_next = ffpa_pkg::FS_SCAN_CMP;
                end
            end
            ffpa_pkg::FS_SCAN_CMP:
            begin
                if (op_reg == ffpa_pkg::OP_ALLOC)
                begin
                    if (cand_end > OW'(e_start))
                    begin
                        if (OW'(e_aligned) > off_reg)
                        begin
                            off_next = OW'(e_aligned);
                        end
                        idx_next   = idx_reg + 1'b1;
                        state_next = ffpa_pkg::FS_SCAN_RD;
                    end
                    else if (cand_end > OW'(pool_reg))
                    begin
                        st_next    = ffpa_pkg::ST_NO_SPACE;
                        state_next = ffpa_pkg::FS_DONE;
                    end
                    else
                    begin
                        pos_next   = idx_reg;
                        idx_next   = live_reg;
                        state_next = ffpa_pkg::FS_SH_RD;
                    end
                end
                else if (foff_reg == {16'd0, e_start})
                begin
                    rel_next   = e_len;
                    used_next  = used_reg - e_len;
                    state_next = ffpa_pkg::FS_SH_RD;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ffpa_pkg::FS_SCAN_RD;
                end
            end
            ffpa_pkg::FS_SH_RD:
            begin
                if (op_reg == ffpa_pkg::OP_ALLOC)
                begin
                    if (idx_reg == pos_reg)
                    begin
                        mem_we     = 1'b1;
                        mem_wd     = {off_reg[31:0], size_reg};
                        live_next  = live_reg + 1'b1;
                        used_next  = used_reg + size_reg;
                        grant_next = base_reg + 48'(off_reg[31:0]);
                        state_next = ffpa_pkg::FS_DONE;
                    end
                    else
                    begin
                        mem_ra     = IW'(idx_reg - 1'b1);
                        state_next = ffpa_pkg::FS_SH_WR;
                    end
                end
                else if (idx_reg + 1'b1 >= live_reg)
                begin
                    live_next  = live_reg - 1'b1;
                    state_next = ffpa_pkg::FS_DONE;
                end
                else
                begin
                    mem_ra     = IW'(idx_reg + 1'b1);
                    state_next = ffpa_pkg::FS_SH_WR;
                end
            end
            ffpa_pkg::FS_SH_WR:
            begin
                mem_we     = 1'b1;
                state_next = ffpa_pkg::FS_SH_RD;
                if (op_reg == ffpa_pkg::OP_ALLOC)
                begin
                    idx_next = idx_reg - 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ffpa_pkg::FS_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_st_next    = st_reg;
                    rsp_grant_next = grant_reg;
                    rsp_rel_next   = rel_reg;
                    rsp_used_next  = used_reg;
                    state_next     = ffpa_pkg::FS_IDLE;
                end
            end
            default:
            begin
                state_next = ffpa_pkg::FS_IDLE;
            end
        endcase
    end

    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= CW'(ffpa_pkg::MAX_BLOCKS))
        else $error("live count above table size");

    a_scan_idx: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ffpa_pkg::FS_SCAN_RD |-> idx_reg <= live_reg)
        else $error("scan index past live count");

    a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ffpa_pkg::FS_SH_WR || state_reg == ffpa_pkg::FS_SH_RD))
        else $error("table written outside move phase");

    a_done_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ffpa_pkg::FS_DONE && !(rsp_valid_reg && rsp_stall) |=> rsp_valid_reg)
        else $error("finished request not presented");

endmodule
